// ----- rtl/core/box_filter_image_downscaler_top_defines.svh -----
// Assertion macros shared by the downscaler checker.
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_TOP_DEFINES_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_TOP_DEFINES_SVH

// Check cons in the cycle after ante.
`define BFDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Check cons in the same cycle as ante.
`define BFDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bfds_pkg.sv -----
// Types and constants of the box filter downscaler.
package bfds_pkg;

	localparam int SUM_W      = 58;
	localparam int CH_N       = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_W = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_H = 3'd4;

	localparam logic        RST_MODE  = 1'b1;
	localparam logic [13:0] RST_SRC_W = 14'd1920;
	localparam logic [13:0] RST_SRC_H = 14'd1080;
	localparam logic [12:0] RST_DST_W = 13'd960;
	localparam logic [12:0] RST_DST_H = 13'd540;

	localparam logic [14:0] HALF_INF = 15'h7C00;

	typedef struct packed {
		logic signed [31:0] chan0_in;
		logic signed [31:0] chan1_in;
		logic signed [31:0] chan2_in;
		logic signed [31:0] chan3_in;
	} pix_t;

	typedef struct packed {
		logic [11:0] out_column;
		logic [11:0] out_row;
		logic [15:0] chan0_out;
		logic [15:0] chan1_out;
		logic [15:0] chan2_out;
		logic [15:0] chan3_out;
		logic        frame_last;
	} res_t;

	typedef struct packed {
		logic       init_w_go;
		logic       init_h_go;
		logic       sum_go;
		logic       ld_w;
		logic       ld_h;
		logic       accept;
		logic       update;
		logic       mul;
		logic       norm_load;
		logic       norm_step;
		logic       rnd;
		logic       put;
		logic [1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic emit;
		logic small_val;
		logic nrm_msb;
		logic four;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/bfds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfds_ram #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/bfds_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bfds_div #(
	parameter int N_W = 58,
	parameter int D_W = 28
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient,
	output logic [D_W-1:0] remainder
);

	localparam int C_W = $clog2(N_W + 1);

	logic [N_W-1:0] quo_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dvs_q;
	logic [C_W-1:0] cnt_q;
	logic [D_W:0]   trial;
	logic           fits;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= C_W'(N_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? D_W'(trial - {1'b0, dvs_q}) : D_W'(trial);
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/bfds_dp.sv -----
// Datapath: configuration, band tracking, line store, averaging and half conversion.
module bfds_dp import bfds_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH  = 8192,
	parameter int MAX_SOURCE_HEIGHT = 8192,
	parameter int MAX_TARGET_WIDTH  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  pix_t                  pix,
	output res_t                  res,
	output logic                  res_valid,
	input  logic                  res_ready,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int CW    = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int RW    = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int TA    = $clog2(MAX_TARGET_WIDTH);
	localparam int CNT_W = CW + RW;

	logic        mode_q;
	logic [13:0] src_w_q;
	logic [13:0] src_h_q;
	logic [12:0] dst_w_q;
	logic [12:0] dst_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= RST_MODE;
			src_w_q <= RST_SRC_W;
			src_h_q <= RST_SRC_H;
			dst_w_q <= RST_DST_W;
			dst_h_q <= RST_DST_H;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[0];
				CFG_SRC_W: src_w_q <= cfg_data;
				CFG_SRC_H: src_h_q <= cfg_data;
				CFG_DST_W: dst_w_q <= cfg_data[12:0];
				CFG_DST_H: dst_h_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic [15:0] sw_x, sh_x, tw_x, th_x, dw_hi, sw16, sh16, dw16, dh16;
	logic [CW-1:0] sw, dw;
	logic [RW-1:0] sh, dh;

	always_comb begin
		sw_x  = 16'(src_w_q);
		sh_x  = 16'(src_h_q);
		tw_x  = 16'(dst_w_q);
		th_x  = 16'(dst_h_q);
		priority if (sw_x == '0) begin
			sw16 = 16'd1;
		end else if (sw_x > 16'(MAX_SOURCE_WIDTH)) begin
			sw16 = 16'(MAX_SOURCE_WIDTH);
		end else begin
			sw16 = sw_x;
		end
		priority if (sh_x == '0) begin
			sh16 = 16'd1;
		end else if (sh_x > 16'(MAX_SOURCE_HEIGHT)) begin
			sh16 = 16'(MAX_SOURCE_HEIGHT);
		end else begin
			sh16 = sh_x;
		end
		dw_hi = (sw16 < 16'(MAX_TARGET_WIDTH)) ? sw16 : 16'(MAX_TARGET_WIDTH);
		priority if (tw_x == '0) begin
			dw16 = 16'd1;
		end else if (tw_x > dw_hi) begin
			dw16 = dw_hi;
		end else begin
			dw16 = tw_x;
		end
		priority if (th_x == '0) begin
			dh16 = 16'd1;
		end else if (th_x > sh16) begin
			dh16 = sh16;
		end else begin
			dh16 = th_x;
		end
	end

	assign sw = CW'(sw16);
	assign dw = CW'(dw16);
	assign sh = RW'(sh16);
	assign dh = RW'(dh16);

	logic [CW-1:0] src_col_q, col_start_q, col_end_q, fw_q, qw_q, rmw_q;
	logic [RW-1:0] src_row_q, row_start_q, row_end_q, fh_q, qh_q, rmh_q, orow_q;
	logic [TA-1:0] ocol_q;

	logic          col_last, row_last, wrap_c, wrap_r, first, emit;
	logic [CW:0]   acc_w;
	logic [RW:0]   acc_h;
	logic          carry_w, carry_h;
	logic [CW-1:0] fw_nx, cend_nx;
	logic [RW-1:0] fh_nx, rend_nx;

	assign col_last = (CW+1)'(src_col_q) + (CW+1)'(1) == (CW+1)'(col_end_q);
	assign wrap_c   = (CW+1)'(src_col_q) + (CW+1)'(1) == (CW+1)'(sw);
	assign row_last = (RW+1)'(src_row_q) + (RW+1)'(1) == (RW+1)'(row_end_q);
	assign wrap_r   = (RW+1)'(src_row_q) + (RW+1)'(1) == (RW+1)'(sh);
	assign first    = (src_row_q == row_start_q) && (src_col_q == col_start_q);
	assign emit     = col_last && row_last;

	assign acc_w   = (CW+1)'(fw_q) + (CW+1)'(rmw_q);
	assign carry_w = acc_w >= (CW+1)'(dw);
	assign fw_nx   = carry_w ? CW'(acc_w - (CW+1)'(dw)) : CW'(acc_w);
	assign cend_nx = col_end_q + qw_q + CW'(carry_w);
	assign acc_h   = (RW+1)'(fh_q) + (RW+1)'(rmh_q);
	assign carry_h = acc_h >= (RW+1)'(dh);
	assign fh_nx   = carry_h ? RW'(acc_h - (RW+1)'(dh)) : RW'(acc_h);
	assign rend_nx = row_end_q + qh_q + RW'(carry_h);

	logic             div_start, div_busy;
	logic [SUM_W-1:0] div_nd, div_quo;
	logic [CNT_W-1:0] div_dv, div_rem, cnt_q;
	logic signed [SUM_W-1:0] sum_q [CH_N];
	logic signed [SUM_W-1:0] sum_sel;
	logic [SUM_W-1:0] sum_mag;

	assign sum_sel   = sum_q[cmd.ch];
	assign sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
	assign div_start = cmd.init_w_go || cmd.init_h_go || cmd.sum_go;

	always_comb begin
		priority if (cmd.init_w_go) begin
			div_nd = SUM_W'(sw);
			div_dv = CNT_W'(dw);
		end else if (cmd.init_h_go) begin
			div_nd = SUM_W'(sh);
			div_dv = CNT_W'(dh);
		end else begin
			div_nd = sum_mag;
			div_dv = cnt_q;
		end
	end

	bfds_div #(
		.N_W(SUM_W),
		.D_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			col_start_q <= '0;
			col_end_q   <= '0;
			fw_q        <= '0;
			row_start_q <= '0;
			row_end_q   <= '0;
			fh_q        <= '0;
			qw_q        <= '0;
			rmw_q       <= '0;
			qh_q        <= '0;
			rmh_q       <= '0;
		end else if (cmd.ld_w) begin
			qw_q  <= CW'(div_quo);
			rmw_q <= CW'(div_rem);
		end else if (cmd.ld_h) begin
			qh_q        <= RW'(div_quo);
			rmh_q       <= RW'(div_rem);
			src_col_q   <= '0;
			src_row_q   <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			col_start_q <= '0;
			col_end_q   <= qw_q;
			fw_q        <= rmw_q;
			row_start_q <= '0;
			row_end_q   <= RW'(div_quo);
			fh_q        <= RW'(div_rem);
		end else if (cmd.update) begin
			if (wrap_c) begin
				src_col_q   <= '0;
				ocol_q      <= '0;
				col_start_q <= '0;
				col_end_q   <= qw_q;
				fw_q        <= rmw_q;
				if (wrap_r) begin
					src_row_q   <= '0;
					orow_q      <= '0;
					row_start_q <= '0;
					row_end_q   <= qh_q;
					fh_q        <= rmh_q;
				end else begin
					src_row_q <= src_row_q + 1'b1;
					if (row_last) begin
						orow_q      <= orow_q + 1'b1;
						row_start_q <= row_end_q;
						row_end_q   <= rend_nx;
						fh_q        <= fh_nx;
					end
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				if (col_last) begin
					ocol_q      <= ocol_q + 1'b1;
					col_start_q <= col_end_q;
					col_end_q   <= cend_nx;
					fw_q        <= fw_nx;
				end
			end
		end
	end

	pix_t                    pix_q;
	logic signed [31:0]      smp [CH_N];
	logic [SUM_W-1:0]        rd [CH_N];
	logic signed [SUM_W-1:0] sum_nx [CH_N];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q <= pix;
		end
	end

	assign smp[0] = pix_q.chan0_in;
	assign smp[1] = pix_q.chan1_in;
	assign smp[2] = pix_q.chan2_in;
	assign smp[3] = pix_q.chan3_in;

	for (genvar c = 0; c < CH_N; c++) begin : g_ch
		assign sum_nx[c] = first ? SUM_W'(smp[c]) : $signed(rd[c]) + SUM_W'(smp[c]);

		bfds_ram #(
			.WIDTH(SUM_W),
			.DEPTH(MAX_TARGET_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (cmd.update && (mode_q || c == 0)),
			.waddr(ocol_q),
			.wdata(sum_nx[c]),
			.re   (cmd.accept),
			.raddr(ocol_q),
			.rdata(rd[c])
		);
	end

	logic [TA-1:0] ecol_q;
	logic [RW-1:0] erow_q;
	logic          flast_q;
	logic [CW-1:0] bw_q;
	logic [RW-1:0] bh_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int c = 0; c < CH_N; c++) begin
				sum_q[c] <= sum_nx[c];
			end
			ecol_q  <= ocol_q;
			erow_q  <= orow_q;
			flast_q <= wrap_c && wrap_r;
			bw_q    <= col_end_q - col_start_q;
			bh_q    <= row_end_q - row_start_q;
		end
		if (cmd.mul) begin
			cnt_q <= CNT_W'(bw_q) * CNT_W'(bh_q);
		end
	end

	logic [39:0] nrm_q;
	logic [5:0]  p_q;
	logic        sgn_q;
	logic        small_q;
	logic [15:0] half_q [CH_N];

	logic [10:0] mant;
	logic        grd, stk, up;
	logic [11:0] mant_r;
	logic [5:0]  exp_b, exp_r;
	logic [9:0]  man_f;
	logic [15:0] half_c;

	always_comb begin
		mant   = nrm_q[39:29];
		grd    = nrm_q[28];
		stk    = |nrm_q[27:0];
		up     = grd && (stk || mant[0]);
		mant_r = {1'b0, mant} + 12'(up);
		exp_b  = p_q - 6'd9;
		exp_r  = mant_r[11] ? exp_b + 6'd1 : exp_b;
		man_f  = mant_r[11] ? mant_r[10:1] : mant_r[9:0];
		priority if (small_q) begin
			half_c = {sgn_q, 5'b0, nrm_q[9:0]};
		end else if (exp_r >= 6'd31) begin
			half_c = {sgn_q, HALF_INF};
		end else begin
			half_c = {sgn_q, exp_r[4:0], man_f};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			nrm_q   <= {div_quo[31:0], 8'h00};
			p_q     <= 6'd39;
			sgn_q   <= sum_sel[SUM_W-1] && (div_quo != '0);
			small_q <= div_quo[31:2] == '0;
		end else if (cmd.norm_step) begin
			nrm_q <= {nrm_q[38:0], 1'b0};
			p_q   <= p_q - 6'd1;
		end
		if (cmd.mul) begin
			for (int c = 0; c < CH_N; c++) begin
				half_q[c] <= '0;
			end
		end else if (cmd.rnd) begin
			half_q[cmd.ch] <= half_c;
		end
	end

	res_t res_q;
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.put) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			res_q.out_column <= 12'(ecol_q);
			res_q.out_row    <= 12'(erow_q);
			res_q.chan0_out  <= half_q[0];
			res_q.chan1_out  <= half_q[1];
			res_q.chan2_out  <= half_q[2];
			res_q.chan3_out  <= half_q[3];
			res_q.frame_last <= flast_q;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	assign sts.div_busy  = div_busy;
	assign sts.emit      = emit;
	assign sts.small_val = small_q;
	assign sts.nrm_msb   = nrm_q[39];
	assign sts.four      = mode_q;
	assign sts.out_free  = !res_valid_q || res_ready;

endmodule

// ----- rtl/core/bfds_ctrl.sv -----
// Controller state machine sequencing setup, accumulation and averaging.
module bfds_ctrl import bfds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr,
	input  logic pix_valid,
	output logic pix_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_INIT_W = 12'b0000_0000_0001,
		S_WAIT_W = 12'b0000_0000_0010,
		S_INIT_H = 12'b0000_0000_0100,
		S_WAIT_H = 12'b0000_0000_1000,
		S_IDLE   = 12'b0000_0001_0000,
		S_UPD    = 12'b0000_0010_0000,
		S_MUL    = 12'b0000_0100_0000,
		S_DIV    = 12'b0000_1000_0000,
		S_WAIT_D = 12'b0001_0000_0000,
		S_NORM   = 12'b0010_0000_0000,
		S_RND    = 12'b0100_0000_0000,
		S_PUT    = 12'b1000_0000_0000
	} state_t;

	state_t     st_q, st_nx;
	logic [1:0] ch_q;

	always_comb begin
		cmd    = '0;
		cmd.ch = ch_q;
		st_nx  = st_q;
		unique case (st_q)
			S_INIT_W: begin
				cmd.init_w_go = 1'b1;
				st_nx = S_WAIT_W;
			end
			S_WAIT_W: if (!sts.div_busy) begin
				cmd.ld_w = 1'b1;
				st_nx = S_INIT_H;
			end
			S_INIT_H: begin
				cmd.init_h_go = 1'b1;
				st_nx = S_WAIT_H;
			end
			S_WAIT_H: if (!sts.div_busy) begin
				cmd.ld_h = 1'b1;
				st_nx = S_IDLE;
			end
			S_IDLE: if (pix_valid) begin
				cmd.accept = 1'b1;
				st_nx = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				st_nx = sts.emit ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				st_nx = S_DIV;
			end
			S_DIV: begin
				cmd.sum_go = 1'b1;
				st_nx = S_WAIT_D;
			end
			S_WAIT_D: if (!sts.div_busy) begin
				cmd.norm_load = 1'b1;
				st_nx = S_NORM;
			end
			S_NORM: begin
				if (sts.small_val || sts.nrm_msb) begin
					st_nx = S_RND;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				st_nx = (!sts.four || ch_q == 2'd3) ? S_PUT : S_DIV;
			end
			S_PUT: if (sts.out_free) begin
				cmd.put = 1'b1;
				st_nx = S_IDLE;
			end
			default: st_nx = S_INIT_W;
		endcase
		if (cfg_wr) begin
			st_nx = S_INIT_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT_W;
			ch_q <= '0;
		end else begin
			st_q <= st_nx;
			if (cmd.mul) begin
				ch_q <= '0;
			end else if (cmd.rnd) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	assign pix_ready = st_q == S_IDLE;

endmodule

// ----- rtl/core/box_filter_image_downscaler_top.sv -----
// Box filter area-average downscaler top level.
// Source pixels are taken in raster order, one at a time. A pixel takes a read
// of the column's running sums from the line store and then a write back of the
// updated sums. A pixel that closes an output band adds the averaging, done by
// one shared restoring divider at one bit per cycle: per active channel a
// division, a normalizing shift and a rounding step, plus a wait if the
// previous result has not been taken. After reset and after every configuration
// write the block computes the band steps with the same divider and accepts no
// pixel meanwhile; a configuration write restarts the frame. The line store is
// four RAMs of 58-bit sums, one per channel, MAX_TARGET_WIDTH entries each, with
// no clearing pass.
module box_filter_image_downscaler_top import bfds_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH  = 8192,
	parameter int MAX_SOURCE_HEIGHT = 8192,
	parameter int MAX_TARGET_WIDTH  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_t                  pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	bfds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfds_dp #(
		.MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
		.MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
		.MAX_TARGET_WIDTH (MAX_TARGET_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ----- rtl/core/bfds_chk.sv -----
// Port-level checker for the downscaler and its bind.
`include "box_filter_image_downscaler_top_defines.svh"
module bfds_chk import bfds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic pix_valid,
	input logic pix_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	`BFDS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	`BFDS_ASSERT_NEXT(a_pix_gap, pix_valid && pix_ready, !pix_ready, "pixel taken in back-to-back cycles")
	`BFDS_ASSERT_NEXT(a_cfg_setup, cfg_valid && cfg_ready, !pix_ready, "pixel taken right after a register write")
	`BFDS_ASSERT_NOW(a_res_src, $rose(res_valid), $past(!pix_ready), "result appeared while waiting for pixels")

endmodule

bind box_filter_image_downscaler_top bfds_chk u_bfds_chk (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the box filter downscaler: scoreboard plus random traffic.
`timescale 1ns / 100ps

import bfds_pkg::*;

class downscale_scoreboard;
	bit mode;
	bit [13:0] src_w, src_h;
	bit [12:0] dst_w, dst_h;
	longint sums[int];
	longint unsigned col, row, ocol, orow, col_end, row_start, row_end;
	res_t pending[$];
	int errors;

	function longint unsigned eff_sw();
		return (src_w < 1) ? 1 : (src_w > 8192) ? 8192 : src_w;
	endfunction

	function longint unsigned eff_sh();
		return (src_h < 1) ? 1 : (src_h > 8192) ? 8192 : src_h;
	endfunction

	function longint unsigned eff_dw();
		longint unsigned hi;
		hi = (eff_sw() < 4096) ? eff_sw() : 4096;
		return (dst_w < 1) ? 1 : (dst_w > hi) ? hi : dst_w;
	endfunction

	function longint unsigned eff_dh();
		return (dst_h < 1) ? 1 : (dst_h > eff_sh()) ? eff_sh() : dst_h;
	endfunction

	function void restart();
		col = 0;
		row = 0;
		ocol = 0;
		orow = 0;
		row_start = 0;
		col_end = eff_sw() / eff_dw();
		row_end = eff_sh() / eff_dh();
	endfunction

	function void reset_regs();
		mode = RST_MODE;
		src_w = RST_SRC_W;
		src_h = RST_SRC_H;
		dst_w = RST_DST_W;
		dst_h = RST_DST_H;
		restart();
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_MODE: begin
				mode = d[0];
			end
			CFG_SRC_W: begin
				src_w = d;
			end
			CFG_SRC_H: begin
				src_h = d;
			end
			CFG_DST_W: begin
				dst_w = d[12:0];
			end
			CFG_DST_H: begin
				dst_h = d[12:0];
			end
			default: begin
			end
		endcase
		restart();
	endfunction

	function bit [15:0] to_half(longint q);
		longint unsigned mag, m24, mant, rem, hf, expo, word;
		int p, shift;
		bit [15:0] sgn;
		sgn = 0;
		if (q < 0) begin
			sgn = 16'h8000;
			mag = -q;
		end else begin
			mag = q;
		end
		m24 = (mag & 64'hFFFF_FFFF) << 8;
		if (m24 < 1024)
			return sgn | m24[15:0];
		p = 63;
		while (m24[p] == 1'b0)
			p--;
		shift = p - 10;
		mant = m24 >> shift;
		expo = p - 9;
		if (shift > 0) begin
			rem = m24 & ((64'd1 << shift) - 1);
			hf = 64'd1 << (shift - 1);
			if (rem > hf || (rem == hf && mant[0]))
				mant++;
			if (mant == 2048) begin
				mant >>= 1;
				expo++;
			end
		end
		if (expo >= 31)
			return sgn | 16'h7C00;
		word = (expo << 10) | (mant & 64'h3FF);
		return sgn | word[15:0];
	endfunction

	function void note_pixel(pix_t p);
		longint unsigned sw, sh, dw, dh, nch, cstart;
		longint cnt;
		logic signed [31:0] chans [4];
		bit first;
		res_t e;
		bit [15:0] h [4];
		sw = eff_sw();
		sh = eff_sh();
		dw = eff_dw();
		dh = eff_dh();
		nch = mode ? 4 : 1;
		cstart = (ocol * sw) / dw;
		first = (row == row_start) && (col == cstart);
		chans[0] = p.chan0_in;
		chans[1] = p.chan1_in;
		chans[2] = p.chan2_in;
		chans[3] = p.chan3_in;
		for (int c = 0; c < nch; c++) begin
			if (first)
				sums[ocol * 4 + c] = longint'(chans[c]);
			else
				sums[ocol * 4 + c] += longint'(chans[c]);
		end
		if (col + 1 == col_end && row + 1 == row_end) begin
			cnt = (col_end - cstart) * (row_end - row_start);
			for (int c = 0; c < 4; c++)
				h[c] = (c < nch && cnt > 0) ? to_half(sums[ocol * 4 + c] / cnt) : 16'h0;
			e.out_column = ocol[11:0];
			e.out_row = orow[11:0];
			e.chan0_out = h[0];
			e.chan1_out = h[1];
			e.chan2_out = h[2];
			e.chan3_out = h[3];
			e.frame_last = (col + 1 == sw && row + 1 == sh);
			pending = {pending, e};
		end
		if (col + 1 == col_end) begin
			ocol++;
			col_end = ((ocol + 1) * sw) / dw;
		end
		col++;
		if (col >= sw) begin
			col = 0;
			ocol = 0;
			col_end = sw / dw;
			if (row + 1 == row_end) begin
				orow++;
				row_start = row_end;
				row_end = ((orow + 1) * sh) / dh;
			end
			row++;
			if (row >= sh) begin
				row = 0;
				orow = 0;
				row_start = 0;
				row_end = sh / dh;
			end
		end
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0h, want %0h", what, got, want);
		errors++;
	endtask

	task check(res_t r);
		res_t e;
		if (pending.size() == 0) begin
			report("unexpected output pixel", r.out_column, 0);
			return;
		end
		e = pending.pop_front();
		if (r.out_column !== e.out_column) report("out_column", r.out_column, e.out_column);
		if (r.out_row !== e.out_row) report("out_row", r.out_row, e.out_row);
		if (r.chan0_out !== e.chan0_out) report("chan0_out", r.chan0_out, e.chan0_out);
		if (r.chan1_out !== e.chan1_out) report("chan1_out", r.chan1_out, e.chan1_out);
		if (r.chan2_out !== e.chan2_out) report("chan2_out", r.chan2_out, e.chan2_out);
		if (r.chan3_out !== e.chan3_out) report("chan3_out", r.chan3_out, e.chan3_out);
		if (r.frame_last !== e.frame_last) report("frame_last", r.frame_last, e.frame_last);
	endtask
endclass

module testbench;
	import bfds_pkg::*;

	localparam int SETTLE = 500;
	localparam int LIMIT = 20000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic pix_valid, pix_ready;
	pix_t pix;
	logic res_valid, res_ready;
	res_t res;

	downscale_scoreboard sb;
	bit calm, hold_req;
	int idle_cycles;
	int rand_done;

	box_filter_image_downscaler_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function logic [31:0] pick_sample();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 511) - 256;
			3: return $urandom_range(0, 2097151) - 1048576;
			default: return $urandom;
		endcase
	endfunction

	task send_pixel(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
		pix = '{a, b, c, d};
		pix_valid = 1;
		do
			@(posedge clk);
		while (!pix_ready);
		sb.note_pixel(pix);
		@(negedge clk);
		if (!calm && $urandom_range(3) == 0) begin
			pix_valid = 0;
			repeat ($urandom_range(1, 8))
				@(negedge clk);
		end
	endtask

	task send_random(int n);
		repeat (n)
			send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample());
	endtask

	task settle();
		pix_valid = 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task set_all(bit m, int sw, int sh, int tw, int th);
		write_cfg(CFG_MODE, CFG_DATA_W'(m));
		write_cfg(CFG_SRC_W, CFG_DATA_W'(sw));
		write_cfg(CFG_SRC_H, CFG_DATA_W'(sh));
		write_cfg(CFG_DST_W, CFG_DATA_W'(tw));
		write_cfg(CFG_DST_H, CFG_DATA_W'(th));
	endtask

	initial begin
		res_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready = 0;
				repeat (400)
					@(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(5) == 0) begin
				res_ready = 0;
				repeat ($urandom_range(0, 7))
					@(negedge clk);
			end else begin
				res_ready = 1;
			end
		end
	end

	always @(posedge clk) begin
		if (res_valid && res_ready)
			sb.check(res);
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int sw, sh, n;
		sb = new();
		sb.reset_regs();
		calm = 0;
		hold_req = 0;
		idle_cycles = 0;
		rand_done = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		pix_valid = 0;
		pix = '0;
		arst_n = 0;
		repeat (2)
			@(negedge clk);
		arst_n = 1;

		send_random(4);
		settle();

		set_all(1, 2, 2, 1, 1);
		repeat (4) send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
		repeat (4) send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3FF);
		send_pixel(32'h1, 32'h0, 32'h3, 32'hFFFF_FFFD);
		send_pixel(32'h0, 32'h0, 32'h2, 32'h1_0000);
		send_pixel(32'h1, 32'h0, 32'h0, 32'hFFFF_0000);
		send_pixel(32'h0, 32'h0, 32'h1, 32'h0);
		settle();

		set_all(0, 3, 3, 3, 3);
		send_pixel(32'h0000_0004, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFC, 32'h0, 32'h0, 32'h0);
		send_random(7);
		settle();

		set_all(1, 0, 0, 0, 0);
		hold_req = 1;
		send_random(20);
		settle();

		set_all(1, 16383, 1, 8191, 1);
		write_cfg(3'd7, 14'h3FFF);
		send_random(10);
		settle();

		while (rand_done < 1150) begin
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 12);
			set_all(1'($urandom_range(1)), sw, sh, $urandom_range(0, sw + 2),
				$urandom_range(0, sh + 2));
			if ($urandom_range(9) == 0)
				write_cfg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
			n = sw * sh * $urandom_range(1, 3);
			if ($urandom_range(7) == 0)
				n = $urandom_range(1, n);
			calm = (rand_done > 950);
			send_random(n);
			rand_done += n;
			settle();
		end

		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bfds_pkg.sv
rtl/core/bfds_ram.sv
rtl/core/bfds_div.sv
rtl/core/bfds_dp.sv
rtl/core/bfds_ctrl.sv
rtl/core/box_filter_image_downscaler_top.sv
rtl/core/bfds_chk.sv
verif/testbench.sv
